[rtl/core/mpm_pkg.sv]
package mpm_pkg;

   // Coefficient store geometry
   localparam int MaxTerms = 1024;
   localparam int AddrW    = $clog2(MaxTerms);

   // Field widths
   localparam int ModeW  = 2;
   localparam int PosW   = 11;
   localparam int CoefW  = 30;
   localparam int ModW   = 31;
   localparam int DegW   = 10;
   localparam int ProdW  = 2 * CoefW;
   localparam int CsrIdxW = 2;

   localparam logic [ModW-1:0] ModulusReset = 31'd1000000007;

   // Item modes
   localparam logic [ModeW-1:0] ModeFirst  = 2'd0;
   localparam logic [ModeW-1:0] ModeSecond = 2'd1;
   localparam logic [ModeW-1:0] ModeQuery  = 2'd2;

   // Register indexes
   localparam logic [CsrIdxW-1:0] CsrModulus     = 2'd0;
   localparam logic [CsrIdxW-1:0] CsrDegreeFirst = 2'd1;
   localparam logic [CsrIdxW-1:0] CsrDegreeSecond = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic [ModW-1:0] modulus;
      logic [DegW-1:0] degree_first;
      logic [DegW-1:0] degree_second;
   } cfg_type;

   typedef struct packed {
      logic             we;
      logic [AddrW-1:0] waddr;
      logic [CoefW-1:0] wdata;
      logic             re;
      logic [AddrW-1:0] raddr;
   } mem_req_type;

   typedef struct packed {
      logic             valid;
      logic             last;
      logic [ProdW-1:0] value;
   } red_in_type;

   typedef struct packed {
      logic            valid;
      logic            last;
      logic [ModW-1:0] rem;
   } red_out_type;

endpackage

[rtl/core/mpm_ram.sv]
module mpm_ram #(
   parameter int Width = 30,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

[rtl/core/mpm_reduce.sv]
module mpm_reduce import mpm_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic [ModW-1:0] modulus,
   input  red_in_type      red_in,
   output red_out_type     red_out
);

   // One quotient bit per stage, most significant bit first
   logic [ModW-1:0]  rem_ff  [ProdW];
   logic [ProdW-1:0] val_ff  [ProdW];
   logic             vld_ff  [ProdW];
   logic             lst_ff  [ProdW];

   logic [ModW-1:0]  rem_src [ProdW];
   logic [ProdW-1:0] val_src [ProdW];
   logic             vld_src [ProdW];
   logic             lst_src [ProdW];
   logic [ModW-1:0]  rem_in  [ProdW];
   logic [ProdW-1:0] val_in  [ProdW];

   always_comb begin
      rem_src[0] = '0;
      val_src[0] = red_in.value;
      vld_src[0] = red_in.valid;
      lst_src[0] = red_in.last;
      for (int s = 1; s < ProdW; s++) begin
         rem_src[s] = rem_ff[s-1];
         val_src[s] = val_ff[s-1];
         vld_src[s] = vld_ff[s-1];
         lst_src[s] = lst_ff[s-1];
      end
   end

   always_comb begin
      logic [ModW:0] trial;
      for (int s = 0; s < ProdW; s++) begin
         trial = {rem_src[s], val_src[s][ProdW-1]};
         if (trial >= {1'b0, modulus}) begin
            rem_in[s] = ModW'(trial - {1'b0, modulus});
         end else begin
            rem_in[s] = trial[ModW-1:0];
         end
         val_in[s] = val_src[s] << 1;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < ProdW; s++) begin
         rem_ff[s] <= rem_in[s];
         val_ff[s] <= val_in[s];
         lst_ff[s] <= lst_src[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < ProdW; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else begin
         for (int s = 0; s < ProdW; s++) begin
            vld_ff[s] <= vld_src[s];
         end
      end
   end

   // A modulus of zero or one reduces everything to zero
   assign red_out.valid = vld_ff[ProdW-1];
   assign red_out.last  = lst_ff[ProdW-1];
   assign red_out.rem   = (modulus < ModW'(2)) ? '0 : rem_ff[ProdW-1];

endmodule

[rtl/core/mpm_ctrl.sv]
module mpm_ctrl import mpm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [ModeW-1:0]  req_mode,
   input  logic [PosW-1:0]   req_pos,
   input  logic [CoefW-1:0]  req_coeff,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [PosW-1:0]   rsp_index,
   output logic [CoefW-1:0]  rsp_value,
   output mem_req_type       mem_first,
   output mem_req_type       mem_second,
   input  logic [CoefW-1:0]  rdata_first,
   input  logic [CoefW-1:0]  rdata_second,
   output red_in_type        red_in,
   input  red_out_type       red_out
);

   state_type        state_ff, state_in;
   logic [PosW-1:0]  pos_ff, pos_in;
   logic [AddrW-1:0] idx_ff, idx_in;
   logic [AddrW-1:0] jdx_ff, jdx_in;
   logic [AddrW-1:0] hi_ff, hi_in;
   logic [ModW-1:0]  acc_ff, acc_in;
   logic             op_write_ff, op_write_in;
   logic             op_first_ff, op_first_in;
   logic             rd_vld_ff, rd_vld_in;
   logic             rd_last_ff, rd_last_in;
   logic             mul_vld_ff;
   logic             mul_last_ff;
   logic [ProdW-1:0] mul_ff, mul_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [PosW-1:0]  rsp_index_ff, rsp_index_in;
   logic [CoefW-1:0] rsp_value_ff, rsp_value_in;

   logic             accept;
   logic             issue;
   logic [DegW-1:0]  df, ds;
   logic [PosW-1:0]  deg_sum;
   logic [PosW-1:0]  lo_full;
   logic [ModW:0]    acc_sum;
   logic [ModW-1:0]  acc_next;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign issue     = (state_ff == ST_ISSUE);

   // Clamp the degrees to the store depth
   assign df = (cfg.degree_first > DegW'(MaxTerms - 1)) ? DegW'(MaxTerms - 1)
                                                        : cfg.degree_first;
   assign ds = (cfg.degree_second > DegW'(MaxTerms - 1)) ? DegW'(MaxTerms - 1)
                                                         : cfg.degree_second;
   assign deg_sum = PosW'(df) + PosW'(ds);
   assign lo_full = (req_pos > PosW'(ds)) ? req_pos - PosW'(ds) : '0;

   assign mul_in = ProdW'(rdata_first) * ProdW'(rdata_second);

   // Running sum stays below the modulus, so one subtract suffices
   assign acc_sum  = {1'b0, acc_ff} + {1'b0, red_out.rem};
   assign acc_next = (acc_sum >= {1'b0, cfg.modulus}) ?
                     ModW'(acc_sum - {1'b0, cfg.modulus}) : acc_sum[ModW-1:0];

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      idx_in       = idx_ff;
      jdx_in       = jdx_ff;
      hi_in        = hi_ff;
      acc_in       = acc_ff;
      op_write_in  = op_write_ff;
      op_first_in  = op_first_ff;
      rd_vld_in    = 1'b0;
      rd_last_in   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_index_in = rsp_index_ff;
      rsp_value_in = rsp_value_ff;

      red_in.valid = mul_vld_ff;
      red_in.last  = mul_last_ff;
      red_in.value = mul_ff;

      if (red_out.valid && !op_write_ff) begin
         acc_in = acc_next;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pos_in = req_pos;
               case (req_mode)
                  ModeFirst, ModeSecond: begin
                     op_write_in = 1'b1;
                     op_first_in = (req_mode == ModeFirst);
                     if (req_pos < PosW'(MaxTerms)) begin
                        red_in.valid = 1'b1;
                        red_in.last  = 1'b1;
                        red_in.value = ProdW'(req_coeff);
                        state_in     = ST_DRAIN;
                     end
                  end
                  ModeQuery: begin
                     op_write_in = 1'b0;
                     acc_in      = '0;
                     idx_in      = AddrW'(lo_full);
                     jdx_in      = AddrW'(req_pos - lo_full);
                     hi_in       = (req_pos < PosW'(df)) ? AddrW'(req_pos) : AddrW'(df);
                     if (req_pos > deg_sum) begin
                        state_in = ST_REPLY;
                     end else begin
                        state_in = ST_ISSUE;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_ISSUE: begin
            rd_vld_in  = 1'b1;
            rd_last_in = (idx_ff == hi_ff);
            idx_in     = idx_ff + AddrW'(1);
            jdx_in     = jdx_ff - AddrW'(1);
            if (idx_ff == hi_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (red_out.valid && red_out.last) begin
               state_in = op_write_ff ? ST_IDLE : ST_REPLY;
            end
         end
         ST_REPLY: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = pos_ff;
               rsp_value_in = acc_ff[CoefW-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      mem_first.we     = red_out.valid && op_write_ff && op_first_ff;
      mem_first.waddr  = pos_ff[AddrW-1:0];
      mem_first.wdata  = red_out.rem[CoefW-1:0];
      mem_first.re     = issue;
      mem_first.raddr  = idx_ff;
      mem_second.we    = red_out.valid && op_write_ff && !op_first_ff;
      mem_second.waddr = pos_ff[AddrW-1:0];
      mem_second.wdata = red_out.rem[CoefW-1:0];
      mem_second.re    = issue;
      mem_second.raddr = jdx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_vld_ff    <= 1'b0;
         mul_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_vld_in;
         mul_vld_ff   <= rd_vld_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      idx_ff       <= idx_in;
      jdx_ff       <= jdx_in;
      hi_ff        <= hi_in;
      acc_ff       <= acc_in;
      op_write_ff  <= op_write_in;
      op_first_ff  <= op_first_in;
      rd_last_ff   <= rd_last_in;
      mul_last_ff  <= rd_last_ff;
      mul_ff       <= mul_in;
      rsp_index_ff <= rsp_index_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_index = rsp_index_ff;
   assign rsp_value = rsp_value_ff;

endmodule

[rtl/core/modular_polynomial_multiply.sv]
// Channel   Direction  Payload (lowest bits first)
// req_      in         tuser: mode; tdata: position[10:0], coeff_in[40:11], zero pad
// rsp_      out        tdata: product_index[10:0], product_value[40:11], zero pad
// csr_      in         index: register number; data: register value
//
// A coefficient write passes the 60-stage modular reduction pipeline
// before it lands in its coefficient memory.
// A query of n term pairs issues one memory read pair per cycle; the
// pairs then pass the multiplier, the reduction pipeline and the accumulator.
// A query beyond the sum of the degrees skips the memories and replies with zero.
// Reset is synchronous and leaves the coefficient memories untouched.
// A result waits in the output register while the next item is taken; a
// reply holds until that register is free.
module modular_polynomial_multiply import mpm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [47:0]        req_tdata,   // position, coeff_in, pad
   input  logic [ModeW-1:0]   req_tuser,   // mode
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [47:0]        rsp_tdata,   // product_index, product_value, pad
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [ModW-1:0]    csr_data
);

   logic [ModW-1:0] modulus_ff;
   logic [DegW-1:0] degree_first_ff;
   logic [DegW-1:0] degree_second_ff;

   cfg_type         cfg;
   mem_req_type     mem_first;
   mem_req_type     mem_second;
   logic [CoefW-1:0] rdata_first;
   logic [CoefW-1:0] rdata_second;
   red_in_type      red_in;
   red_out_type     red_out;
   logic [PosW-1:0]  rsp_index;
   logic [CoefW-1:0] rsp_value;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff       <= ModulusReset;
         degree_first_ff  <= '0;
         degree_second_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CsrModulus:      modulus_ff       <= csr_data;
            CsrDegreeFirst:  degree_first_ff  <= csr_data[DegW-1:0];
            CsrDegreeSecond: degree_second_ff <= csr_data[DegW-1:0];
            default: begin
               // drop writes to unknown registers
            end
         endcase
      end
   end

   assign cfg.modulus       = modulus_ff;
   assign cfg.degree_first  = degree_first_ff;
   assign cfg.degree_second = degree_second_ff;

   mpm_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_mode     (req_tuser),
      .req_pos      (req_tdata[PosW-1:0]),
      .req_coeff    (req_tdata[PosW+CoefW-1:PosW]),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_index    (rsp_index),
      .rsp_value    (rsp_value),
      .mem_first    (mem_first),
      .mem_second   (mem_second),
      .rdata_first  (rdata_first),
      .rdata_second (rdata_second),
      .red_in       (red_in),
      .red_out      (red_out)
   );

   assign rsp_tdata = {7'b0, rsp_value, rsp_index};

   mpm_ram #(
      .Width (CoefW),
      .Depth (MaxTerms)
   ) u_ram_first (
      .clock (clock),
      .we    (mem_first.we),
      .waddr (mem_first.waddr),
      .wdata (mem_first.wdata),
      .re    (mem_first.re),
      .raddr (mem_first.raddr),
      .rdata (rdata_first)
   );

   mpm_ram #(
      .Width (CoefW),
      .Depth (MaxTerms)
   ) u_ram_second (
      .clock (clock),
      .we    (mem_second.we),
      .waddr (mem_second.waddr),
      .wdata (mem_second.wdata),
      .re    (mem_second.re),
      .raddr (mem_second.raddr),
      .rdata (rdata_second)
   );

   mpm_reduce u_reduce (
      .clock   (clock),
      .reset   (reset),
      .modulus (modulus_ff),
      .red_in  (red_in),
      .red_out (red_out)
   );

   // Work still in the reduction pipeline means the block is busy
   a_busy_while_reducing: assert property (
      @(posedge clock) disable iff (reset)
      red_out.valid |-> !req_tready
   ) else $error("item accepted while reduction pipeline busy");

   // Only one coefficient memory takes a write at a time
   a_single_write: assert property (
      @(posedge clock) disable iff (reset)
      !(mem_first.we && mem_second.we)
   ) else $error("both coefficient memories written together");

   // A fresh result only follows a query in progress
   a_result_from_query: assert property (
      @(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready)
   ) else $error("result appeared without a query in progress");

   // Memory reads only happen while no coefficient write lands
   a_no_read_on_write: assert property (
      @(posedge clock) disable iff (reset)
      (mem_first.we || mem_second.we) |-> !(mem_first.re || mem_second.re)
   ) else $error("coefficient read overlaps a write");

endmodule
